>>> src/ltbc_pkg.sv
// Shared types and constants for the LED timeout and blink controller.
// No dependencies.
package ltbc_pkg;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_ON      = 3'd1,
        CMD_OFF     = 3'd2,
        CMD_BLINK   = 3'd3,
        CMD_ENDLESS = 3'd4
    } t_cmd;

    localparam int CNT_W = 16;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt CNT_MAX = '1;

    localparam t_cnt ON_TIME_RST      = 16'd3000;
    localparam t_cnt BLINK_PERIOD_RST = 16'd500;

    // Register indexes on the configuration port.
    localparam logic REG_ON_TIME      = 1'b0;
    localparam logic REG_BLINK_PERIOD = 1'b1;

    localparam int PIN_W = 2;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == CNT_MAX) ? v : t_cnt'(v + 1'b1);
    endfunction

endpackage

>>> src/led_timeout_blink_controller_unit.sv
// Top level of the LED timeout and blink controller: command decode, LED
// state, configuration registers and the result register.
// Depends on ltbc_pkg.

// Each accepted item is one command (tick, turn on, turn off, set blink, set
// endless) and yields one result item that shows the pin levels and mode flags
// after the command. The block takes one item per cycle: the whole update is
// a single pass of compares and saturating increments between the LED state
// registers and the result register, and a new item is accepted whenever the
// result register is empty or its item is taken in the same cycle. A result
// appears in the cycle after its item is accepted. on_time sits at byte address 0
// and blink_period at byte address 4 of the APB port; both should be written
// only while no item is in flight.
module led_timeout_blink_controller_unit #(
    parameter int LED_COUNT = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Command channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_cmd,
    input  logic                        i_led,
    input  logic                        i_flag,
    // Result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ltbc_pkg::PIN_W-1:0]  o_pin_levels,
    output logic                        o_blink_on,
    output logic                        o_endless_on,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ltbc_pkg::*;

    // Configuration registers
    t_cnt r_on_time;
    t_cnt r_blink_period;

    // LED state
    logic [LED_COUNT-1:0] r_lit,     n_lit;
    logic [LED_COUNT-1:0] r_pin,     n_pin;
    t_cnt                 r_elapsed [LED_COUNT];
    t_cnt                 n_elapsed [LED_COUNT];
    logic                 r_blink,   n_blink;
    logic                 r_endless, n_endless;
    t_cnt                 r_phase,   n_phase;

    // Result register
    logic                 r_out_valid;
    logic [PIN_W-1:0]     r_out_pins, n_out_pins;
    logic                 r_out_blink;
    logic                 r_out_endless;

    logic in_acc;
    logic cfg_wr;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;

    // Configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time      <= ON_TIME_RST;
            r_blink_period <= BLINK_PERIOD_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ON_TIME:      r_on_time      <= pwdata[CNT_W-1:0];
                REG_BLINK_PERIOD: r_blink_period <= pwdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_ON_TIME:      prdata = {{(32-CNT_W){1'b0}}, r_on_time};
            REG_BLINK_PERIOD: prdata = {{(32-CNT_W){1'b0}}, r_blink_period};
            default:          prdata = '0;
        endcase
    end

    // Command update
    always_comb begin
        logic expired;
        logic hit;
        t_cnt phase_inc;

        n_lit     = r_lit;
        n_pin     = r_pin;
        n_elapsed = r_elapsed;
        n_blink   = r_blink;
        n_endless = r_endless;
        n_phase   = r_phase;
        expired   = 1'b0;
        hit       = 1'b0;
        phase_inc = sat_inc(r_phase);

        unique case (i_cmd)
            CMD_TICK: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                    if (r_lit[i]) begin
                        n_elapsed[i] = sat_inc(r_elapsed[i]);
                    end
                end
                n_phase = phase_inc;
                // Only the first expired LED is switched off on a tick.
                for (int i = 0; i < LED_COUNT; i++) begin
                    if (!expired && r_lit[i] && !r_endless &&
                        (n_elapsed[i] > r_on_time)) begin
                        expired  = 1'b1;
                        n_blink  = 1'b0;
                        n_lit[i] = 1'b0;
                        n_pin[i] = 1'b0;
                    end
                end
                if (!expired && r_blink && (phase_inc > r_blink_period)) begin
                    n_pin   = r_pin ^ r_lit;
                    n_phase = t_cnt'(phase_inc - r_blink_period);
                end
            end
            CMD_ON: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                    hit = (32'(i_led) == i);
                    if (hit && !r_lit[i]) begin
                        n_lit[i]     = 1'b1;
                        n_pin[i]     = 1'b1;
                        n_elapsed[i] = '0;
                    end
                end
            end
            CMD_OFF: begin
                for (int i = 0; i < LED_COUNT; i++) begin
                    hit = (32'(i_led) == i);
                    if (hit) begin
                        n_lit[i] = 1'b0;
                        n_pin[i] = 1'b0;
                    end
                end
            end
            CMD_BLINK: begin
                if (i_flag && !r_blink) begin
                    n_phase = '0;
                end
                n_blink = i_flag;
            end
            CMD_ENDLESS: begin
                n_endless = i_flag;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_pins = '0;
        for (int i = 0; i < LED_COUNT && i < PIN_W; i++) begin
            n_out_pins[i] = n_pin[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit     <= '0;
            r_pin     <= '0;
            r_blink   <= 1'b0;
            r_endless <= 1'b0;
            r_phase   <= '0;
            for (int i = 0; i < LED_COUNT; i++) begin
                r_elapsed[i] <= '0;
            end
        end else if (in_acc) begin
            r_lit     <= n_lit;
            r_pin     <= n_pin;
            r_blink   <= n_blink;
            r_endless <= n_endless;
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_pins    <= n_out_pins;
            r_out_blink   <= n_blink;
            r_out_endless <= n_endless;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pin_levels = r_out_pins;
    assign o_blink_on   = r_out_blink;
    assign o_endless_on = r_out_endless;

    // A pin can only be driven high while its LED is lit.
    a_pin_needs_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pin & ~r_lit) == '0)
        else $error("pin driven high for an unlit LED");

    // Every accepted item leaves a result in the output register.
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted item produced no result");

    // In endless mode a tick never switches a LED off.
    a_endless_keeps_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_TICK) && r_endless) |=> (r_lit == $past(r_lit)))
        else $error("tick switched off a LED in endless mode");

    // The blink and endless flags in the result match the internal state after the item.
    a_blink_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_out_blink == r_blink) && (r_out_endless == r_endless))
        else $error("result flags differ from controller state");

endmodule
